>>> hdl/sdfw_pkg.sv
// Package for the signed distance field window: request types, FSM states,
// sizing constants and the distance-to-byte mapping tables.
// No dependencies.
package sdfw_pkg;

  localparam int unsigned MaxWidthDef  = 128;
  localparam int unsigned MaxHeightDef = 128;
  localparam int unsigned RadiusDef    = 8;
  localparam int unsigned Threshold    = 128;
  localparam int unsigned Spread       = 8;
  localparam int unsigned TblMax       = 128;
  localparam int unsigned ResetDim     = 32;

  localparam logic [7:0] CfgWidth  = 8'd0;
  localparam logic [7:0] CfgHeight = 8'd1;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] sdf_value;
    logic       frame_last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ME,
    ST_SCAN,
    ST_FLUSH,
    ST_RESULT
  } state_e;

  // Exact floor(255*clamp((d+S)/2S,0,1)) with d = +-sqrt(d2), evaluated at elaboration.
  function automatic logic [7:0] map_byte(int unsigned d2, bit is_in);
    longint k;
    longint t;
    longint scaled;
    logic [7:0] res;
    res = 8'd0;
    scaled = 64'(65025) * longint'(d2);
    for (k = 255; k > 0; k--) begin
      if (is_in) begin
        t = 2 * Spread * k - 255 * Spread;
        if ((t <= 0 || t * t <= scaled) && res == 8'd0) res = 8'(k);
      end else begin
        t = 255 * Spread - 2 * Spread * k;
        if (t >= 0 && scaled <= t * t && res == 8'd0) res = 8'(k);
      end
    end
    return res;
  endfunction

  typedef logic [7:0] tbl_t [TblMax+1];

  function automatic tbl_t build_tbl(bit is_in);
    tbl_t tbl;
    for (int i = 0; i <= TblMax; i++) tbl[i] = map_byte(i, is_in);
    return tbl;
  endfunction

  localparam tbl_t InsideTbl  = build_tbl(1'b1);
  localparam tbl_t OutsideTbl = build_tbl(1'b0);

endpackage

>>> hdl/signed_distance_field_window.sv
// An item that completes a window starts a search (states ME, SCAN, FLUSH, RESULT)
// over the (2R+1)^2 window, R = SEARCH_RADIUS; the window is read one bit per cycle.
// Throughput: one item per cycle if no result is due, else none until the result is loaded.
// Reset: counters cleared, both frame dimensions set to 32; the pixel memory is not cleared.
// Holds the top level; depends on sdfw_pkg.
module signed_distance_field_window
  import sdfw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT    = MaxHeightDef,
  parameter int unsigned SEARCH_RADIUS = RadiusDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_req_t    in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_req_t   out_req_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CNTW  = $clog2(Depth + 1);
  localparam int unsigned DW    = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int unsigned CW    = DW + 2;
  localparam int unsigned Span  = 2 * SEARCH_RADIUS;
  localparam int unsigned OW    = $clog2(Span + 1);
  localparam int unsigned RW    = $clog2(SEARCH_RADIUS + 1);
  localparam int unsigned SW    = $clog2(2 * SEARCH_RADIUS * SEARCH_RADIUS + 1);

  logic mem_q [Depth];
  logic rd_data_q;

  state_e state_q, state_d;
  logic [7:0] cfg_w_q, cfg_h_q;
  logic [CNTW-1:0] rcv_q, emit_q;
  logic [DW-1:0] ex_q, ey_q;
  logic [OW-1:0] sdy_q, sdx_q;
  logic me_q, found_q, rd_valid_q, rd_me_q;
  logic [SW-1:0] best_q, rd_d2_q;
  logic out_valid_q;
  out_req_t out_q;

  logic [DW-1:0] w_eff, h_eff, nxc, nyc;
  logic [CNTW-1:0] total, rcv_new, need;
  logic store, emit_now, accept, last_step, load_out, frame_end;
  logic signed [CW-1:0] ny_s, nx_s;
  logic win_ok;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic [RW-1:0] ody, odx;
  logic [SW-1:0] d2;
  logic [7:0] tidx;
  out_req_t res;

  always_comb begin
    w_eff = (cfg_w_q == 8'd0) ? DW'(1) :
            (32'(cfg_w_q) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(cfg_w_q);
    h_eff = (cfg_h_q == 8'd0) ? DW'(1) :
            (32'(cfg_h_q) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : DW'(cfg_h_q);
    total = CNTW'(w_eff) * CNTW'(h_eff);
  end

  assign accept  = in_valid_i && in_ready_o;
  assign store   = accept && !in_req_i.kind && (rcv_q < total);
  assign rcv_new = store ? rcv_q + CNTW'(1) : rcv_q;

  always_comb begin
    nxc = (32'(ex_q) + SEARCH_RADIUS > 32'(w_eff) - 1) ? w_eff - DW'(1)
                                                       : ex_q + DW'(SEARCH_RADIUS);
    nyc = (32'(ey_q) + SEARCH_RADIUS > 32'(h_eff) - 1) ? h_eff - DW'(1)
                                                       : ey_q + DW'(SEARCH_RADIUS);
    need = CNTW'(nyc) * CNTW'(w_eff) + CNTW'(nxc);
    emit_now = accept && (emit_q < rcv_new) && (need < rcv_new);
  end

  always_comb begin
    ny_s = signed'(CW'(ey_q) + CW'(sdy_q) - CW'(SEARCH_RADIUS));
    nx_s = signed'(CW'(ex_q) + CW'(sdx_q) - CW'(SEARCH_RADIUS));
    win_ok = !ny_s[CW-1] && !nx_s[CW-1] && (ny_s[CW-2:0] < (CW-1)'(h_eff))
             && (nx_s[CW-2:0] < (CW-1)'(w_eff));
    ody = (sdy_q >= OW'(SEARCH_RADIUS)) ? RW'(sdy_q - OW'(SEARCH_RADIUS))
                                        : RW'(OW'(SEARCH_RADIUS) - sdy_q);
    odx = (sdx_q >= OW'(SEARCH_RADIUS)) ? RW'(sdx_q - OW'(SEARCH_RADIUS))
                                        : RW'(OW'(SEARCH_RADIUS) - sdx_q);
    d2 = SW'(ody) * SW'(ody) + SW'(odx) * SW'(odx);
    last_step = (sdy_q == OW'(Span)) && (sdx_q == OW'(Span));
    rd_en = (state_q == ST_ME) || (state_q == ST_SCAN && win_ok);
    if (state_q == ST_ME) begin
      rd_addr = AW'(ey_q) * AW'(w_eff) + AW'(ex_q);
    end else begin
      rd_addr = AW'(ny_s[CW-2:0]) * AW'(w_eff) + AW'(nx_s[CW-2:0]);
    end
  end

  always_comb begin
    tidx = (32'(best_q) > TblMax) ? 8'(TblMax) : 8'(best_q);
    if (!found_q) begin
      res.sdf_value = me_q ? 8'd255 : 8'd0;
    end else begin
      res.sdf_value = me_q ? InsideTbl[tidx] : OutsideTbl[tidx];
    end
    res.frame_last = (emit_q + CNTW'(1) == total);
    frame_end = res.frame_last;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (emit_now) state_d = ST_ME;
      ST_ME:     state_d = ST_SCAN;
      ST_SCAN:   if (last_step) state_d = ST_FLUSH;
      ST_FLUSH:  state_d = ST_RESULT;
      ST_RESULT: if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cfg_ready_o = 1'b1;
    load_out    = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);
    out_valid_o = out_valid_q;
    out_req_o   = out_q;
  end

  always_ff @(posedge clk_i) begin
    if (store) mem_q[rcv_q[AW-1:0]] <= (in_req_i.pixel_value > 8'(Threshold));
    if (rd_en) rd_data_q <= mem_q[rd_addr];
    rd_d2_q <= d2;
    if (load_out) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_w_q     <= 8'(ResetDim);
      cfg_h_q     <= 8'(ResetDim);
      rcv_q       <= '0;
      emit_q      <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      sdy_q       <= '0;
      sdx_q       <= '0;
      me_q        <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      rd_valid_q  <= 1'b0;
      rd_me_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= (state_q == ST_SCAN) && win_ok;
      rd_me_q    <= (state_q == ST_ME);
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (store) rcv_q <= rcv_new;
      if (state_q == ST_ME) begin
        sdy_q   <= '0;
        sdx_q   <= '0;
        found_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        if (sdx_q == OW'(Span)) begin
          sdx_q <= '0;
          sdy_q <= sdy_q + OW'(1);
        end else begin
          sdx_q <= sdx_q + OW'(1);
        end
      end
      if (rd_me_q) me_q <= rd_data_q;
      if (rd_valid_q && (rd_data_q != me_q) && (!found_q || rd_d2_q < best_q)) begin
        best_q  <= rd_d2_q;
        found_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (frame_end) begin
          emit_q <= '0;
          rcv_q  <= '0;
          ex_q   <= '0;
          ey_q   <= '0;
        end else begin
          emit_q <= emit_q + CNTW'(1);
          if (ex_q == w_eff - DW'(1)) begin
            ex_q <= '0;
            ey_q <= ey_q + DW'(1);
          end else begin
            ex_q <= ex_q + DW'(1);
          end
        end
      end
      if (cfg_valid_i && (cfg_index_i == CfgWidth || cfg_index_i == CfgHeight)) begin
        if (cfg_index_i == CfgWidth) cfg_w_q <= cfg_data_i;
        else cfg_h_q <= cfg_data_i;
        rcv_q  <= '0;
        emit_q <= '0;
        ex_q   <= '0;
        ey_q   <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_emit_le_rcv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= rcv_q) else $error("emitted count passed received count");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("request taken while busy");
  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RESULT))
    else $error("result shown outside the result state");
`endif

endmodule

>>> test/signed_distance_field_window_tb.sv
// Self-checking testbench for signed_distance_field_window: drives glyph frames of
// several sizes and shapes and checks every distance byte against a built-in predictor.
// Depends on sdfw_pkg and the RTL top level.
module signed_distance_field_window_tb
  import sdfw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CellCount = MaxWidthDef * MaxHeightDef;
  localparam int unsigned SettleCycles = 320;
  localparam logic [7:0] CfgUnused = 8'd7;

  class sdf_scoreboard;
    bit          inside_map[CellCount];
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    int unsigned recv_count;
    int unsigned emit_count;
    out_req_t    pending_bytes[$];
    int          errors;

    function new();
      width_reg = 8'(ResetDim);
      height_reg = 8'(ResetDim);
      recv_count = 0;
      emit_count = 0;
      errors = 0;
    endfunction

    function int unsigned clip_dim(logic [7:0] v, int unsigned maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned cur_w();
      return clip_dim(width_reg, MaxWidthDef);
    endfunction

    function int unsigned cur_h();
      return clip_dim(height_reg, MaxHeightDef);
    endfunction

    function void configure(logic [7:0] idx, logic [7:0] data);
      if (idx == CfgWidth) width_reg = data;
      else if (idx == CfgHeight) height_reg = data;
      else return;
      recv_count = 0;
      emit_count = 0;
    endfunction

    // Largest k with floor semantics of 255*clamp((d+8)/16,0,1), d = +-sqrt(d2).
    function logic [7:0] distance_byte(int d2, bit is_in);
      int k;
      int lhs;
      k = 0;
      while (k < 255) begin
        if (is_in) begin
          lhs = 2 * Spread * (k + 1) - 255 * Spread;
          if (!(lhs <= 0 || lhs * lhs <= 65025 * d2)) break;
        end else begin
          lhs = 255 * Spread - 2 * Spread * (k + 1);
          if (!(lhs >= 0 && 65025 * d2 <= lhs * lhs)) break;
        end
        k++;
      end
      return 8'(k);
    endfunction

    function logic [7:0] pixel_byte(int x, int y, int w, int h);
      bit me;
      bit found;
      int best;
      int d2;
      me = inside_map[y * w + x];
      found = 0;
      best = 0;
      for (int dy = -int'(RadiusDef); dy <= int'(RadiusDef); dy++) begin
        for (int dx = -int'(RadiusDef); dx <= int'(RadiusDef); dx++) begin
          if (y + dy < 0 || y + dy >= h || x + dx < 0 || x + dx >= w) continue;
          if (inside_map[(y + dy) * w + x + dx] == me) continue;
          d2 = dx * dx + dy * dy;
          if (!found || d2 < best) begin
            best = d2;
            found = 1;
          end
        end
      end
      if (!found) return me ? 8'd255 : 8'd0;
      return distance_byte(best, me);
    endfunction

    function void note(in_req_t r);
      int unsigned w, h, total, x, y, nx, ny;
      out_req_t res;
      w = cur_w();
      h = cur_h();
      total = w * h;
      if (!r.kind && recv_count < total) begin
        inside_map[recv_count] = r.pixel_value > Threshold;
        recv_count++;
      end
      if (emit_count >= recv_count) return;
      x = emit_count % w;
      y = emit_count / w;
      nx = (x + RadiusDef > w - 1) ? w - 1 : x + RadiusDef;
      ny = (y + RadiusDef > h - 1) ? h - 1 : y + RadiusDef;
      if (ny * w + nx >= recv_count) return;
      res.sdf_value = pixel_byte(x, y, w, h);
      res.frame_last = (emit_count + 1 == total);
      pending_bytes = {pending_bytes, res};
      emit_count++;
      if (emit_count == total) begin
        emit_count = 0;
        recv_count = 0;
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check(out_req_t got);
      out_req_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.sdf_value !== want.sdf_value)
        report_mismatch($sformatf("sdf_value %0d, expected %0d", got.sdf_value, want.sdf_value));
      if (got.frame_last !== want.frame_last)
        report_mismatch($sformatf("frame_last %b, expected %b", got.frame_last, want.frame_last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_req_t    in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_req_t   out_req;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  sdf_scoreboard sb = new();
  bit calm = 0;
  int items_sent = 0;
  int out_stall = 0;

  signed_distance_field_window dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 15) == 0) out_stall <= $urandom_range(1, 10);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_req);
  end

  task send_item(logic kind, logic [7:0] value);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req.kind = kind;
    in_req.pixel_value = value;
    do @(posedge clk); while (!in_ready);
    sb.note(in_req);
    items_sent++;
    @(negedge clk);
  endtask

  task write_reg(logic [7:0] idx, logic [7:0] data);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task wait_idle();
    in_valid = 1'b0;
    while (sb.pending_bytes.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function logic [7:0] coverage(bit is_in);
    if ($urandom_range(0, 9) == 0) return is_in ? 8'd129 : 8'd128;
    return is_in ? 8'($urandom_range(129, 255)) : 8'($urandom_range(0, 128));
  endfunction

  // Shapes: noise, disc, flat, half plane.
  task send_frame(int shape, int unsigned npix, bit flush);
    int unsigned w, h, cx, cy, rad;
    bit flat_class;
    bit is_in;
    w = sb.cur_w();
    h = sb.cur_h();
    cx = $urandom_range(0, w - 1);
    cy = $urandom_range(0, h - 1);
    rad = $urandom_range(0, 10);
    flat_class = $urandom_range(0, 1);
    for (int unsigned i = 0; i < npix; i++) begin
      case (shape)
        0: begin
          is_in = $urandom_range(0, 1);
        end
        1: begin
          is_in = ((int'(i % w) - int'(cx)) ** 2 + (int'(i / w) - int'(cy)) ** 2) <= rad * rad;
        end
        2: begin
          is_in = flat_class;
        end
        default: begin
          is_in = (int'(i % w) + int'(i / w)) > int'(cx + cy);
        end
      endcase
      send_item(1'b0, coverage(is_in));
    end
    if (flush) begin
      while (sb.recv_count != 0 || sb.emit_count != 0)
        send_item($urandom_range(0, 4) != 0, 8'($urandom));
    end
    wait_idle();
  endtask

  task frame_with(logic [7:0] w, logic [7:0] h, int shape);
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
    send_frame(shape, sb.cur_w() * sb.cur_h(), 1);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(CfgWidth, 8'd0);
    write_reg(CfgHeight, 8'd0);
    send_item(1'b1, 8'd255);
    send_item(1'b0, 8'd129);
    send_item(1'b0, 8'd128);
    send_item(1'b1, 8'd0);
    wait_idle();

    write_reg(CfgWidth, 8'd2);
    write_reg(CfgHeight, 8'd2);
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd128);
    send_item(1'b0, 8'd129);
    send_item(1'b1, 8'd170);
    send_item(1'b1, 8'd85);
    send_item(1'b1, 8'd0);
    wait_idle();

    // A pixel landing on a fully received frame is dropped.
    write_reg(CfgWidth, 8'd3);
    write_reg(CfgHeight, 8'd1);
    send_item(1'b0, 8'd200);
    send_item(1'b0, 8'd10);
    send_item(1'b0, 8'd200);
    send_item(1'b0, 8'd255);
    send_item(1'b1, 8'd0);
    send_item(1'b1, 8'd0);
    wait_idle();

    // Partial frame abandoned by a width write; an unused index changes nothing.
    write_reg(CfgWidth, 8'd4);
    write_reg(CfgHeight, 8'd4);
    send_frame(0, 5, 0);
    write_reg(CfgUnused, 8'd2);
    send_frame(0, 3, 0);
    write_reg(CfgWidth, 8'd4);
    send_frame(1, 16, 1);

    frame_with(8'd255, 8'd1, 3);
    frame_with(8'd1, 8'd128, 0);
    frame_with(8'd60, 8'd2, 1);

    while (items_sent < 650) begin
      if (items_sent > 560) calm = 1;
      frame_with(8'($urandom_range(1, 14)), 8'($urandom_range(1, 14)), $urandom_range(0, 3));
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
